// ----- rtl/rspi_pkg.sv -----
// ----------------------------------------------------------------------------
// rspi_pkg: shared types and constants
// Payload structures, register codes and pipeline sizes for the ray segment
// versus plane intersection block.
// ----------------------------------------------------------------------------
package rspi_pkg;

	localparam int DOT_ST = 3;
	localparam int QW     = 17;
	localparam int DIV_ST = QW;
	localparam int PT_ST  = 2;
	localparam int NST    = DOT_ST + DIV_ST + PT_ST;

	// Width of the divider operands; dividend below 2^49, divisor below 2^48.
	localparam int DW = 51;
	localparam int DNW = 50;

	localparam logic [QW-1:0] ONE_Q16 = QW'(65536);

	localparam logic [2:0] REG_NX  = 3'd0;
	localparam logic [2:0] REG_NY  = 3'd1;
	localparam logic [2:0] REG_NZ  = 3'd2;
	localparam logic [2:0] REG_OFF = 3'd3;
	localparam logic [2:0] REG_EPS = 3'd4;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] off;
		logic [16:0]        eps;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
	} ray_t;

	typedef struct packed {
		ray_t          ray;
		logic          miss;
		logic [DW-1:0] rem;
		logic [DW-1:0] dv;
		logic [QW-1:0] quo;
	} div_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} res_t;

endpackage

// ----- rtl/ray_segment_plane_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_segment_plane_intersect: segment versus plane test
// Streams rays through a fully pipelined Q16.16 intersection datapath.
// ----------------------------------------------------------------------------
// The block accepts one ray per clock cycle while the output side keeps up
// and returns one result per ray, in order. The pipeline has three dot
// product stages, a seventeen stage divider that resolves one quotient
// bit per stage, and two stages that scale the direction and add the
// start point. Every stage holds its data while the next is full, so empty
// stages close up during a stall and s_tready drops only when the whole
// pipeline is occupied.
module ray_segment_plane_intersect (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          s_tvalid,
	output logic          s_tready,
	// start_x, start_y, start_z, dir_x, dir_y, dir_z
	input  logic [191:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// point_x, point_y, point_z
	output logic [95:0]   m_tdata,
	// hit
	output logic          m_tuser
);
	import rspi_pkg::*;

	cfg_t           cfg;
	ray_t           ray_in;
	div_t           dot_out, div_out;
	res_t           res;
	logic [NST-1:0] v_q;
	logic [NST-1:0] rdy;

	assign ray_in.sx = s_tdata[31:0];
	assign ray_in.sy = s_tdata[63:32];
	assign ray_in.sz = s_tdata[95:64];
	assign ray_in.dx = s_tdata[127:96];
	assign ray_in.dy = s_tdata[159:128];
	assign ray_in.dz = s_tdata[191:160];

	// A stage takes new data when it is empty or its contents move on.
	always_comb begin
		rdy[NST-1] = !v_q[NST-1] || m_tready;
		for (int k = NST - 2; k >= 0; k--)
			rdy[k] = !v_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0])
				v_q[0] <= s_tvalid;
			for (int k = 1; k < NST; k++) begin
				if (rdy[k])
					v_q[k] <= v_q[k-1];
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = v_q[NST-1];
	assign m_tdata  = {res.pz, res.py, res.px};
	assign m_tuser  = res.hit;

	rspi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rspi_dot u_dot (
		.clk    (clk),
		.ld     (rdy[DOT_ST-1:0]),
		.cfg    (cfg),
		.ray_in (ray_in),
		.dout   (dot_out)
	);

	rspi_div u_div (
		.clk  (clk),
		.ld   (rdy[DOT_ST+DIV_ST-1:DOT_ST]),
		.din  (dot_out),
		.dout (div_out)
	);

	rspi_point u_point (
		.clk (clk),
		.ld  (rdy[NST-1:DOT_ST+DIV_ST]),
		.din (div_out),
		.res (res)
	);

endmodule

// ----- rtl/rspi_cfg.sv -----
// ----------------------------------------------------------------------------
// rspi_cfg: configuration registers
// APB-style register file holding the plane normal, offset and epsilon.
// ----------------------------------------------------------------------------
module rspi_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output rspi_pkg::cfg_t cfg
);
	import rspi_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nx  <= '0;
			cfg_q.ny  <= 32'sd65536;
			cfg_q.nz  <= '0;
			cfg_q.off <= '0;
			cfg_q.eps <= 17'd1;
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_NX:  cfg_q.nx  <= pwdata;
				REG_NY:  cfg_q.ny  <= pwdata;
				REG_NZ:  cfg_q.nz  <= pwdata;
				REG_OFF: cfg_q.off <= pwdata;
				REG_EPS: cfg_q.eps <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_NX:  prdata = cfg_q.nx;
			REG_NY:  prdata = cfg_q.ny;
			REG_NZ:  prdata = cfg_q.nz;
			REG_OFF: prdata = cfg_q.off;
			REG_EPS: prdata = {15'd0, cfg_q.eps};
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/rspi_dot.sv -----
// ----------------------------------------------------------------------------
// rspi_dot: dot product stages
// Three stages: products, floored sums, then miss tests and divider operands.
// ----------------------------------------------------------------------------
module rspi_dot (
	input  logic                        clk,
	input  logic [rspi_pkg::DOT_ST-1:0] ld,
	input  rspi_pkg::cfg_t              cfg,
	input  rspi_pkg::ray_t              ray_in,
	output rspi_pkg::div_t              dout
);
	import rspi_pkg::*;

	ray_t               ray_s1, ray_s2, ray_s3;
	logic signed [63:0] pd_s1 [3];
	logic signed [63:0] ps_s1 [3];
	logic signed [DNW-1:0] den_s2;
	logic signed [DW-1:0]  t_s2;
	logic                  miss_s3;
	logic [DW-1:0]         a_s3, b_s3;

	logic signed [65:0]   dsum, nsum;
	logic signed [DW-1:0] epsum, tnext;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			ray_s1   <= ray_in;
			pd_s1[0] <= ray_in.dx * cfg.nx;
			pd_s1[1] <= ray_in.dy * cfg.ny;
			pd_s1[2] <= ray_in.dz * cfg.nz;
			ps_s1[0] <= ray_in.sx * cfg.nx;
			ps_s1[1] <= ray_in.sy * cfg.ny;
			ps_s1[2] <= ray_in.sz * cfg.nz;
		end
	end

	always_comb begin
		dsum  = 66'(pd_s1[0]) + 66'(pd_s1[1]) + 66'(pd_s1[2]);
		nsum  = 66'(ps_s1[0]) + 66'(ps_s1[1]) + 66'(ps_s1[2]);
		tnext = DW'($signed(nsum[65:16])) + DW'(cfg.off);
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			ray_s2 <= ray_s1;
			den_s2 <= dsum[65:16];
			t_s2   <= tnext;
		end
	end

	// The ray misses when it faces away or runs parallel, or when the start
	// lies on or behind the plane.
	assign epsum = DW'(den_s2) + DW'($signed({1'b0, cfg.eps}));

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			ray_s3  <= ray_s2;
			miss_s3 <= (epsum > 0) || (den_s2 == '0) || (t_s2 <= 0);
			a_s3    <= t_s2;
			b_s3    <= -(DW'(den_s2));
		end
	end

	always_comb begin
		dout.ray  = ray_s3;
		dout.miss = miss_s3;
		dout.rem  = a_s3;
		dout.dv   = b_s3;
		dout.quo  = '0;
	end

endmodule

// ----- rtl/rspi_div.sv -----
// ----------------------------------------------------------------------------
// rspi_div: restoring divider pipeline
// One quotient bit per stage; the first stage also rejects quotients of two
// or more, so seventeen bits cover the whole useful range of u.
// ----------------------------------------------------------------------------
module rspi_div (
	input  logic                        clk,
	input  logic [rspi_pkg::DIV_ST-1:0] ld,
	input  rspi_pkg::div_t              din,
	output rspi_pkg::div_t              dout
);
	import rspi_pkg::*;

	div_t stg_s [DIV_ST];

	generate
		for (genvar k = 0; k < DIV_ST; k++) begin : g_st
			div_t          prev;
			logic [DW-1:0] r2;
			logic          bit_q;
			logic          big;

			if (k == 0) begin : g_first
				assign prev = din;
				assign r2   = din.rem;
				assign big  = !(din.rem < (din.dv << 1));
			end else begin : g_next
				assign prev = stg_s[k-1];
				assign r2   = stg_s[k-1].rem << 1;
				assign big  = 1'b0;
			end

			assign bit_q = (r2 >= prev.dv);

			always_ff @(posedge clk) begin
				if (ld[k]) begin
					stg_s[k].ray  <= prev.ray;
					stg_s[k].miss <= prev.miss || big;
					stg_s[k].dv   <= prev.dv;
					stg_s[k].rem  <= bit_q ? r2 - prev.dv : r2;
					stg_s[k].quo  <= {prev.quo[QW-2:0], bit_q};
				end
			end
		end
	endgenerate

	assign dout = stg_s[DIV_ST-1];

endmodule

// ----- rtl/rspi_point.sv -----
// ----------------------------------------------------------------------------
// rspi_point: hit point stages
// Scales direction by u, adds start point with saturation; zero on a miss.
// ----------------------------------------------------------------------------
module rspi_point (
	input  logic                       clk,
	input  logic [rspi_pkg::PT_ST-1:0] ld,
	input  rspi_pkg::div_t             din,
	output rspi_pkg::res_t             res
);
	import rspi_pkg::*;

	logic signed [49:0] prod_s1 [3];
	logic signed [31:0] st_s1 [3];
	logic               miss_s1;
	res_t               res_s2;

	logic signed [QW:0] us;
	logic signed [34:0] sum [3];
	logic signed [31:0] sat [3];

	assign us = $signed({1'b0, din.quo});

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			prod_s1[0] <= din.ray.dx * us;
			prod_s1[1] <= din.ray.dy * us;
			prod_s1[2] <= din.ray.dz * us;
			st_s1[0]   <= din.ray.sx;
			st_s1[1]   <= din.ray.sy;
			st_s1[2]   <= din.ray.sz;
			miss_s1    <= din.miss || (din.quo == '0) || (din.quo > ONE_Q16);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = 35'(st_s1[i]) + 35'($signed(prod_s1[i][49:16]));
			if (sum[i] > 35'sd2147483647)
				sat[i] = 32'sh7fffffff;
			else if (sum[i] < -35'sd2147483648)
				sat[i] = 32'sh80000000;
			else
				sat[i] = sum[i][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			res_s2.hit <= !miss_s1;
			res_s2.px  <= miss_s1 ? '0 : sat[0];
			res_s2.py  <= miss_s1 ? '0 : sat[1];
			res_s2.pz  <= miss_s1 ? '0 : sat[2];
		end
	end

	assign res = res_s2;

endmodule

// ----- rtl/rspi_chk.sv -----
// ----------------------------------------------------------------------------
// rspi_chk: port checker
// Watches the stream ports of the intersection block over time.
// ----------------------------------------------------------------------------
module rspi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result holds still until its transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A miss carries an all zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with nonzero point");

	// With the output stage empty the whole pipeline can move.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// A draining output never blocks the input.
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

endmodule

bind ray_segment_plane_intersect rspi_chk u_chk (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for ray_segment_plane_intersect
// Drives rays over the input stream and plane settings over the register
// port, predicts each hit flag and intersection point, and checks every
// result transfer in order against the prediction.
// ----------------------------------------------------------------------------
import rspi_pkg::*;

class plane_hit_board;
	res_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	static function logic signed [63:0] floor16(logic signed [95:0] x);
		logic signed [95:0] t;
		t = x >>> 16;
		return t[63:0];
	endfunction

	// Exact three-term sum, then floor division by 2^16.
	static function logic signed [63:0] dot3(logic signed [31:0] a0, logic signed [31:0] a1,
			logic signed [31:0] a2, logic signed [31:0] b0, logic signed [31:0] b1,
			logic signed [31:0] b2);
		logic signed [95:0] s;
		s = 96'(a0) * 96'(b0) + 96'(a1) * 96'(b1) + 96'(a2) * 96'(b2);
		return floor16(s);
	endfunction

	static function logic signed [31:0] sat(logic signed [95:0] x);
		if (x > 96'sd2147483647)
			return 32'sh7fffffff;
		if (x < -96'sd2147483648)
			return 32'sh80000000;
		return x[31:0];
	endfunction

	function void note_ray(cfg_t c, ray_t r);
		res_t e;
		logic signed [63:0] denom, numer, u;
		logic [63:0] a, b, q, rm;
		logic signed [95:0] p;
		e = '0;
		denom = dot3(c.nx, c.ny, c.nz, r.dx, r.dy, r.dz);
		numer = -(dot3(c.nx, c.ny, c.nz, r.sx, r.sy, r.sz) + 64'(c.off));
		if (!(denom > -$signed({47'd0, c.eps}) || denom == 0) && numer < 0) begin
			a = -numer;
			b = -denom;
			q = a / b;
			rm = a % b;
			if (q < 2) begin
				u = q * 65536 + (rm << 16) / b;
				if (u > 0 && u <= 65536) begin
					e.hit = 1'b1;
					p = 96'(r.sx) + 96'(floor16(96'(r.dx) * 96'(u)));
					e.px = sat(p);
					p = 96'(r.sy) + 96'(floor16(96'(r.dy) * 96'(u)));
					e.py = sat(p);
					p = 96'(r.sz) + 96'(floor16(96'(r.dz) * 96'(u)));
					e.pz = sat(p);
				end
			end
		end
		pending.push_back(e);
	endfunction

	function void check_point(logic hit, logic [95:0] pts);
		res_t e;
		if (pending.size() == 0) begin
			$error("unexpected result transfer");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (hit !== e.hit) begin
			$error("hit expected %0d actual %0d", e.hit, hit);
			errors++;
		end
		if (pts[31:0] !== e.px) begin
			$error("point_x expected %0d actual %0d", e.px, $signed(pts[31:0]));
			errors++;
		end
		if (pts[63:32] !== e.py) begin
			$error("point_y expected %0d actual %0d", e.py, $signed(pts[63:32]));
			errors++;
		end
		if (pts[95:64] !== e.pz) begin
			$error("point_z expected %0d actual %0d", e.pz, $signed(pts[95:64]));
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [191:0] s_tdata;
	logic [95:0] m_tdata;

	plane_hit_board board = new();
	cfg_t plane;
	int send_idle, recv_idle;

	ray_segment_plane_intersect dut (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_point(m_tuser, m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// The select lines stay up between back to back writes; set_plane drops them.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_NX: plane.nx = val;
			REG_NY: plane.ny = val;
			REG_NZ: plane.nz = val;
			REG_OFF: plane.off = val;
			default: plane.eps = val[16:0];
		endcase
	endtask

	task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
			logic [31:0] off, logic [31:0] eps);
		write_reg(REG_NX, nx);
		write_reg(REG_NY, ny);
		write_reg(REG_NZ, nz);
		write_reg(REG_OFF, off);
		write_reg(REG_EPS, eps);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// The valid line stays up after a transfer so rays can follow back to back.
	task automatic send_ray(ray_t r);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r.dz, r.dy, r.dx, r.sz, r.sy, r.sx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_ray(plane, r);
	endtask

	function automatic logic [31:0] pick();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(8 << 16)) - (4 << 16);
		endcase
	endfunction

	// With a unit normal along y, mostly rays that start in front of the plane and point into it.
	function automatic ray_t aimed_ray();
		ray_t r;
		r.sx = pick();
		r.sy = pick();
		r.sz = pick();
		r.dx = pick();
		r.dy = pick();
		r.dz = pick();
		if ($urandom_range(3) != 0 && plane.ny == 32'sd65536 && plane.nx == 0
				&& plane.nz == 0) begin
			r.sy = $urandom_range(3 << 16) - plane.off;
			r.dy = -$signed($urandom_range(6 << 16));
		end
		return r;
	endfunction

	task automatic directed();
		ray_t r;
		r = '0;
		send_ray(r);
		r.sy = 32'sd65536; r.dy = -32'sd131072;          // hit at half
		send_ray(r);
		r.dy = -32'sd65536;                              // hit at segment end
		send_ray(r);
		r.dy = -32'sd65535;                              // just beyond the end
		send_ray(r);
		r.dy = 32'sd65536;                               // facing away
		send_ray(r);
		r.sy = -32'sd65536; r.dy = -32'sd65536;          // start behind
		send_ray(r);
		r.sy = 0;                                        // start on the plane
		send_ray(r);
		r.sx = 32'h7fffffff; r.dx = 32'h7fffffff; r.sy = 32'sd65536; r.dy = -32'sd65536;
		send_ray(r);                                      // saturating point
		r.sx = 32'h80000000; r.dx = 32'h80000000; r.sz = 32'hffffffff; r.dz = 32'h80000001;
		send_ray(r);
		r = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000};
		send_ray(r);
		r.dy = -32'sd1;                                   // tiny denominator, eps 1
		send_ray(r);
	endtask

	task automatic random_phase(int n);
		repeat (n) send_ray(aimed_ray());
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		plane = '{0, 65536, 0, 0, 1};
		send_idle = 14;
		recv_idle = 73;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		drain();
		set_plane(0, 32'sd65536, 0, 0, 0);
		r_zero_denominator: begin
			ray_t z;
			z = '0; z.sy = 32'sd65536; z.dx = 32'sd65536;
			send_ray(z);
		end
		random_phase(150);
		drain();
		send_idle = 73;
		recv_idle = 14;
		set_plane(0, 32'sd65536, 0, 32'sd65536, 32'sd65536);
		random_phase(150);
		drain();
		set_plane(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000, 32'h1ffff);
		random_phase(60);
		drain();
		send_idle = 0;
		recv_idle = 0;
		set_plane($urandom, $urandom, $urandom, $urandom, $urandom);
		random_phase(60);
		drain();
		set_plane(0, 32'sd65536, 0, -32'sd131072, 32'sd1);
		random_phase(218);
		drain();
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/rspi_pkg.sv
rtl/rspi_cfg.sv
rtl/rspi_dot.sv
rtl/rspi_div.sv
rtl/rspi_point.sv
rtl/ray_segment_plane_intersect.sv
rtl/rspi_chk.sv
tb/tb_top.sv
